### hw/rtl/plm_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; imported by the list engine, its storage and its checker.
`default_nettype none

package plm_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int CMD_W            = 3;
  localparam int POS_W            = 8;
  localparam int DATA_W           = 32;

  // Value returned by a get that misses the list.
  localparam logic signed [DATA_W-1:0] NOT_FOUND_VALUE = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/plm_ram.sv
// Entry storage of the positional list engine: one write port, one read port
// with registered read data. Depends on plm_pkg for the data width.
`default_nettype none

module plm_ram
  import plm_pkg::*;
#(
  parameter int DEPTH = DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEFAULT_CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads so a waiting result stays valid.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: command decode, shift sequencer,
// result register. Depends on plm_pkg and instantiates plm_ram.
`default_nettype none

// The block keeps an ordered list of up to CAPACITY signed 32-bit words in a
// single-port-write, single-port-read RAM and takes one command beat at a
// time; in_stall is high while a command is in progress. Append, clear, an
// insert at the end of the list, a delete of the last entry and any ignored
// command complete without leaving S_IDLE. Any other insert runs S_INS,
// S_INS_LAST and S_INS_FIN, and any other delete runs S_DEL and S_DEL_LAST,
// because the sequencer moves one entry per cycle through the RAM (read one
// entry, write it one place over in the next cycle).
// A get reads the RAM and then waits in S_GET_OUT while the previous result
// still waits on out_stall; only get produces an output beat. The next
// command is accepted while a finished result waits to be taken.

module positional_list_engine_unit
  import plm_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic                          out_found
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_INS_FIN,
    S_DEL,
    S_DEL_LAST,
    S_GET_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     last_r, last_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] word_r, word_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wpa_r, wpa_nxt;
  logic              hit_r, hit_nxt;
  logic              outv_r, outv_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              found_r, found_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [CW-1:0] cnt_dec;
  logic          full;

  assign pos_w   = PW'(in_position);
  assign cnt_w   = PW'(cnt_r);
  assign cnt_dec = cnt_r - 1'b1;
  assign full    = (cnt_r == CW'(CAPACITY));

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = outv_r;
  assign out_read_value = data_r;
  assign out_found      = found_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    last_nxt  = last_r;
    pos_nxt   = pos_r;
    word_nxt  = word_r;
    pend_nxt  = 1'b0;
    wpa_nxt   = wpa_r;
    hit_nxt   = hit_r;
    outv_nxt  = outv_r;
    data_nxt  = data_r;
    found_nxt = found_r;
    ram_we    = 1'b0;
    ram_waddr = wpa_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_r;

    if (outv_r && !out_stall) begin
      outv_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_APPEND: begin
              if (!full) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = in_value;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            CMD_INSERT: begin
              if (!full && pos_w <= cnt_w) begin
                if (pos_w == cnt_w) begin
                  ram_we    = 1'b1;
                  ram_waddr = pos_w[AW-1:0];
                  ram_wdata = in_value;
                  cnt_nxt   = cnt_r + 1'b1;
                end else begin
                  pos_nxt   = pos_w[AW-1:0];
                  word_nxt  = in_value;
                  ptr_nxt   = cnt_dec[AW-1:0];
                  state_nxt = S_INS;
                end
              end
            end
            CMD_DELETE: begin
              if (pos_w < cnt_w) begin
                if ((pos_w + PW'(1)) == cnt_w) begin
                  cnt_nxt = cnt_dec;
                end else begin
                  ptr_nxt   = pos_w[AW-1:0] + 1'b1;
                  last_nxt  = cnt_dec[AW-1:0];
                  state_nxt = S_DEL;
                end
              end
            end
            CMD_GET: begin
              hit_nxt   = (pos_w < cnt_w);
              ram_re    = (pos_w < cnt_w);
              ram_raddr = pos_w[AW-1:0];
              state_nxt = S_GET_OUT;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Walk down from the top entry, each word landing one place higher.
      S_INS: begin
        ram_re   = 1'b1;
        pend_nxt = 1'b1;
        wpa_nxt  = ptr_r + 1'b1;
        ram_we   = pend_r;
        if (ptr_r == pos_r) begin
          state_nxt = S_INS_LAST;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      S_INS_LAST: begin
        ram_we    = pend_r;
        state_nxt = S_INS_FIN;
      end
      S_INS_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = word_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_IDLE;
      end
      // Walk up from just above the hole, each word landing one place lower.
      S_DEL: begin
        ram_re   = 1'b1;
        pend_nxt = 1'b1;
        wpa_nxt  = ptr_r - 1'b1;
        ram_we   = pend_r;
        if (ptr_r == last_r) begin
          state_nxt = S_DEL_LAST;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_DEL_LAST: begin
        ram_we    = pend_r;
        cnt_nxt   = cnt_dec;
        state_nxt = S_IDLE;
      end
      S_GET_OUT: begin
        if (!outv_r || !out_stall) begin
          outv_nxt  = 1'b1;
          data_nxt  = hit_r ? ram_rdata : NOT_FOUND_VALUE;
          found_nxt = hit_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      outv_r  <= outv_nxt;
    end
    ptr_r   <= ptr_nxt;
    last_r  <= last_nxt;
    pos_r   <= pos_nxt;
    word_r  <= word_nxt;
    wpa_r   <= wpa_nxt;
    hit_r   <= hit_nxt;
    data_r  <= data_nxt;
    found_r <= found_nxt;
  end

  plm_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/plm_checker.sv
// Port-level checks for positional_list_engine_unit, bound to the top level.
// Depends on plm_pkg for command codes and the miss value.
`default_nettype none

module plm_checker
  import plm_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic [CMD_W-1:0]         in_command,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [DATA_W-1:0] out_read_value,
  input wire logic                     out_found
);

  // A result beat held by the receiver keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_found))
    else $error("output beat changed while stalled");

  // A miss always reports the miss value.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_read_value == NOT_FOUND_VALUE)
    else $error("miss reported with a value other than -1");

  // Only a get produces a result, so no other beat can raise out_valid.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command != CMD_GET |=> !$rose(out_valid))
    else $error("result produced by a command other than get");

  // A get holds off the input until its result is loaded.
  a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_GET |=> in_stall)
    else $error("input accepted while a get was pending");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pending get");

endmodule

bind positional_list_engine_unit plm_checker u_plm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_found      (out_found)
);

`default_nettype wire
